@@ src/rsrt_pkg.sv @@
package rsrt_pkg;

	localparam int RSRT_MAX_RULES = 6;
	localparam int RSRT_QUEUE_DEPTH = 2;

	localparam logic [31:0] RSRT_WILDCARD = 32'hFFFF_FFFF;
	localparam logic [31:0] RSRT_DIFFUSE_BIT = 32'h0000_0001;
	localparam logic [31:0] RSRT_GLOSS_BIT = 32'h0000_0010;

	typedef enum logic [1:0] {
		OP_APPLY = 2'd0,
		OP_ADD = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		RK_PROGRAM = 2'd0,
		RK_DIFFUSE = 2'd1,
		RK_GLOSS = 2'd2,
		RK_MASK = 2'd3
	} kind_t;

	typedef struct packed {
		logic [31:0] prog;
		logic [31:0] diffuse;
		logic [31:0] gloss;
		logic [31:0] config_bits;
	} rec_t;

	typedef struct packed {
		op_t op;
		kind_t kind;
		logic [31:0] match_val;
		logic [31:0] repl_val;
		rec_t rec;
	} cmd_t;

	typedef struct packed {
		logic modified;
		rec_t rec;
		logic [2:0] rule_count;
		logic add_rejected;
	} result_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic full;
		logic avail;
	} qctl_t;

endpackage

@@ src/rsrt_front.sv @@
module rsrt_front import rsrt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic valid,
	output logic stall,
	input logic [1:0] operation,
	input logic [1:0] rule_kind,
	input logic [31:0] match_value,
	input logic [31:0] replace_value,
	input logic [31:0] program_in,
	input logic [31:0] diffuse_texture_in,
	input logic [31:0] gloss_texture_in,
	input logic [31:0] texture_config_in,
	input logic queue_full,
	output logic push,
	output cmd_t cmd
);

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_in;
	logic accept;

	// record fields matter for apply only, rule fields for add only
	always_comb begin
		cmd_in = '0;
		cmd_in.op = op_t'(operation);
		case (op_t'(operation))
			OP_APPLY: begin
				cmd_in.rec.prog = program_in;
				cmd_in.rec.diffuse = diffuse_texture_in;
				cmd_in.rec.gloss = gloss_texture_in;
				cmd_in.rec.config_bits = texture_config_in;
			end
			OP_ADD: begin
				cmd_in.kind = kind_t'(rule_kind);
				cmd_in.match_val = match_value;
				cmd_in.repl_val = replace_value;
			end
			default: begin
			end
		endcase
	end

	assign stall = valid_s1 && queue_full;
	assign accept = valid && !stall;
	assign push = valid_s1 && !queue_full;
	assign cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_in;
		end
	end

endmodule

@@ src/rsrt_queue.sv @@
module rsrt_queue import rsrt_pkg::*; #(
	parameter int DEPTH = RSRT_QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cmd_t wr_cmd,
	input logic pop,
	output cmd_t rd_cmd,
	output qctl_t ctl
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic do_push;
	logic do_pop;

	assign ctl.full = fill_q == CNT_W'(DEPTH);
	assign ctl.avail = fill_q != '0;
	assign do_push = push && !ctl.full;
	assign do_pop = pop && ctl.avail;
	assign ctl.push = do_push;
	assign ctl.pop = do_pop;
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

@@ src/rsrt_back.sv @@
module rsrt_back import rsrt_pkg::*; #(
	parameter int MAX_RULES = RSRT_MAX_RULES
) (
	input logic clk,
	input logic arst_n,
	input cmd_t cmd,
	input logic cmd_avail,
	output logic cmd_pop,
	output result_t result,
	output logic result_valid,
	input logic result_stall
);

	localparam int CNT_W = $clog2(MAX_RULES + 1);
	localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	function automatic logic [2:0] low3(input logic [CNT_W-1:0] n);
		logic [CNT_W+2:0] e;
		e = {3'b000, n};
		return e[2:0];
	endfunction

	state_t state_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;
	logic res_valid_q;
	result_t res_q;

	kind_t kind_q [MAX_RULES];
	logic [31:0] match_q [MAX_RULES];
	logic [31:0] repl_q [MAX_RULES];

	rec_t orig_q;
	rec_t acc_q;
	logic mod_q;

	kind_t cur_kind;
	logic [31:0] cur_match;
	logic [31:0] cur_repl;
	rec_t acc_next;
	logic mod_next;
	logic last_rule;
	logic table_full;
	logic [IDX_W-1:0] wr_idx;
	result_t res_next;
	logic res_load;

	assign cmd_pop = (state_q == ST_IDLE) && cmd_avail && !res_valid_q;
	assign result = res_q;
	assign result_valid = res_valid_q;
	assign table_full = count_q == CNT_W'(MAX_RULES);
	assign last_rule = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
	assign wr_idx = IDX_W'(count_q);

	assign cur_kind = kind_q[idx_q];
	assign cur_match = match_q[idx_q];
	assign cur_repl = repl_q[idx_q];

	// one rule per cycle, matches always test the original record
	always_comb begin
		acc_next = acc_q;
		mod_next = mod_q;
		case (cur_kind)
			RK_PROGRAM: begin
				if (orig_q.prog == cur_match) begin
					acc_next.prog = cur_repl;
					mod_next = 1'b1;
				end
			end
			RK_DIFFUSE: begin
				if (cur_match == RSRT_WILDCARD || orig_q.diffuse == cur_match) begin
					acc_next.diffuse = cur_repl;
					acc_next.config_bits = acc_q.config_bits | RSRT_DIFFUSE_BIT;
					mod_next = 1'b1;
				end
			end
			RK_GLOSS: begin
				acc_next.gloss = cur_repl;
				acc_next.config_bits = acc_q.config_bits | RSRT_GLOSS_BIT;
				mod_next = 1'b1;
			end
			default: begin
				acc_next.config_bits = acc_q.config_bits & cur_repl;
				mod_next = 1'b1;
			end
		endcase
	end

	always_comb begin
		res_next = '0;
		res_load = 1'b0;
		if (state_q == ST_IDLE && cmd_pop) begin
			res_load = 1'b1;
			case (cmd.op)
				OP_APPLY: begin
					res_next.rec = cmd.rec;
					res_next.rule_count = low3(count_q);
				end
				OP_ADD: begin
					if (!table_full) begin
						res_next.rule_count = low3(count_q + CNT_W'(1));
					end else begin
						res_next.rule_count = low3(count_q);
						res_next.add_rejected = 1'b1;
					end
				end
				OP_REMOVE: begin
					res_next.rule_count = (count_q != '0) ? low3(count_q - CNT_W'(1)) : 3'd0;
				end
				default: begin
					res_next.rule_count = 3'd0;
				end
			endcase
		end else if (state_q == ST_WALK && last_rule) begin
			res_load = 1'b1;
			res_next.modified = mod_next;
			res_next.rec = acc_next;
			res_next.rule_count = low3(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						idx_q <= '0;
						case (cmd.op)
							OP_APPLY: begin
								if (count_q == '0) begin
									res_valid_q <= 1'b1;
								end else begin
									state_q <= ST_WALK;
								end
							end
							OP_ADD: begin
								if (!table_full) begin
									count_q <= count_q + CNT_W'(1);
								end
								res_valid_q <= 1'b1;
							end
							OP_REMOVE: begin
								if (count_q != '0) begin
									count_q <= count_q - CNT_W'(1);
								end
								res_valid_q <= 1'b1;
							end
							default: begin
								count_q <= '0;
								res_valid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_WALK: begin
					if (last_rule) begin
						state_q <= ST_IDLE;
						res_valid_q <= 1'b1;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_next;
		end
		if (state_q == ST_IDLE && cmd_pop) begin
			orig_q <= cmd.rec;
			acc_q <= cmd.rec;
			mod_q <= 1'b0;
			if (cmd.op == OP_ADD && !table_full) begin
				kind_q[wr_idx] <= cmd.kind;
				match_q[wr_idx] <= cmd.match_val;
				repl_q[wr_idx] <= cmd.repl_val;
			end
		end else if (state_q == ST_WALK) begin
			acc_q <= acc_next;
			mod_q <= mod_next;
		end
	end

endmodule

@@ src/render_state_rewrite_table.sv @@
// Render-state rewrite table: holds up to MAX_RULES ordered rewrite rules and
// applies them to render records. Items enter through a one-stage front end and
// a two-entry queue, so input is taken while the rule walker is busy or a result
// waits. The back end takes the next item from the queue only once the previous
// result is gone. An add, remove or clear item, or an apply on an empty table,
// goes straight to its result; any other apply item walks the stored rules in
// order, and the walker reads one table entry per cycle. Exactly one result item
// follows each item, in order; an add to a full table leaves the table unchanged
// and sets add_rejected.
module render_state_rewrite_table import rsrt_pkg::*; #(
	parameter int MAX_RULES = RSRT_MAX_RULES
) (
	input logic clk,
	input logic arst_n,
	input logic valid,
	output logic stall,
	input logic [1:0] operation,
	input logic [1:0] rule_kind,
	input logic [31:0] match_value,
	input logic [31:0] replace_value,
	input logic [31:0] program_in,
	input logic [31:0] diffuse_texture_in,
	input logic [31:0] gloss_texture_in,
	input logic [31:0] texture_config_in,
	output logic result_valid,
	input logic result_stall,
	output logic modified,
	output logic [31:0] program_out,
	output logic [31:0] diffuse_texture_out,
	output logic [31:0] gloss_texture_out,
	output logic [31:0] texture_config_out,
	output logic [2:0] rule_count,
	output logic add_rejected
);

	cmd_t front_cmd;
	cmd_t queue_cmd;
	logic front_push;
	logic back_pop;
	qctl_t qctl;
	result_t res;

	rsrt_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.valid(valid),
		.stall(stall),
		.operation(operation),
		.rule_kind(rule_kind),
		.match_value(match_value),
		.replace_value(replace_value),
		.program_in(program_in),
		.diffuse_texture_in(diffuse_texture_in),
		.gloss_texture_in(gloss_texture_in),
		.texture_config_in(texture_config_in),
		.queue_full(qctl.full),
		.push(front_push),
		.cmd(front_cmd)
	);

	rsrt_queue #(
		.DEPTH(RSRT_QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(front_push),
		.wr_cmd(front_cmd),
		.pop(back_pop),
		.rd_cmd(queue_cmd),
		.ctl(qctl)
	);

	rsrt_back #(
		.MAX_RULES(MAX_RULES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(queue_cmd),
		.cmd_avail(qctl.avail),
		.cmd_pop(back_pop),
		.result(res),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

	assign modified = res.modified;
	assign program_out = res.rec.prog;
	assign diffuse_texture_out = res.rec.diffuse;
	assign gloss_texture_out = res.rec.gloss;
	assign texture_config_out = res.rec.config_bits;
	assign rule_count = res.rule_count;
	assign add_rejected = res.add_rejected;

endmodule

@@ src/rsrt_checker.sv @@
module rsrt_checker import rsrt_pkg::*; #(
	parameter int MAX_RULES = RSRT_MAX_RULES
) (
	input logic clk,
	input logic arst_n,
	input logic valid,
	input logic stall,
	input logic [1:0] operation,
	input logic [1:0] rule_kind,
	input logic [31:0] match_value,
	input logic [31:0] replace_value,
	input logic [31:0] program_in,
	input logic [31:0] diffuse_texture_in,
	input logic [31:0] gloss_texture_in,
	input logic [31:0] texture_config_in,
	input logic result_valid,
	input logic result_stall,
	input logic modified,
	input logic [31:0] program_out,
	input logic [31:0] diffuse_texture_out,
	input logic [31:0] gloss_texture_out,
	input logic [31:0] texture_config_out,
	input logic [2:0] rule_count,
	input logic add_rejected
);

	localparam logic [2:0] MAX_LOW = 3'(MAX_RULES);
	localparam bit COUNT_FITS = MAX_RULES <= 7;

	// held result item stays put
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(rule_count)
			&& $stable(program_out) && $stable(texture_config_out))
		else $error("result item changed while stalled");

	// a refused add only happens on a full table and reports no record
	a_reject_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && add_rejected |-> rule_count == MAX_LOW && !modified
			&& program_out == '0 && texture_config_out == '0)
		else $error("add rejected without a full table");

	// count never goes past the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !COUNT_FITS || rule_count <= MAX_LOW)
		else $error("rule count beyond table size");

	// modified results come only from an apply over stored rules, never a refused add
	a_modified_apply: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && modified |-> !add_rejected && rule_count != 3'd0)
		else $error("modified result without stored rules");

endmodule

bind render_state_rewrite_table rsrt_checker #(.MAX_RULES(MAX_RULES)) u_rsrt_checker (.*);
